// ----- rtl/chd_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// chd_pkg
// Shared types and constants for the chunked body decoder.
// ---------------------------------------------------------------------------
package chd_pkg;

    localparam int SIZE_BITS_DEF = 64;
    localparam int QUEUE_DEPTH   = 4;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_SEMI  = 8'h3B;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_END  = 1'b1;

    typedef enum logic [1:0] {
        ST_DATA      = 2'd0,
        ST_COMPLETE  = 2'd1,
        ST_MALFORMED = 2'd2,
        ST_TRUNCATED = 2'd3
    } chd_status_t;

    // classified request handed from front to back
    typedef struct packed {
        logic       cmd;
        logic [7:0] data;
        logic [3:0] hex_val;
        logic       is_hex;
        logic       is_blank;
        logic       is_cr;
        logic       is_lf;
        logic       is_semi;
    } chd_item_t;

endpackage

// ----- rtl/chd_front.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// chd_front
// Accepts input requests and classifies each body byte for the parser.
// ---------------------------------------------------------------------------
module chd_front (
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,
    input  logic              s_tuser,
    input  logic              q_full,
    output logic              q_push,
    output chd_pkg::chd_item_t q_item
);
    import chd_pkg::*;

    logic is_digit;
    logic is_lower;
    logic is_upper;

    always_comb begin
        is_digit = (s_tdata >= 8'h30) && (s_tdata <= 8'h39);
        is_lower = (s_tdata >= 8'h61) && (s_tdata <= 8'h66);
        is_upper = (s_tdata >= 8'h41) && (s_tdata <= 8'h46);

        q_item.cmd      = s_tuser;
        q_item.data     = s_tdata;
        q_item.is_hex   = is_digit || is_lower || is_upper;
        q_item.is_blank = (s_tdata == CHAR_SPACE) || (s_tdata == CHAR_TAB);
        q_item.is_cr    = (s_tdata == CHAR_CR);
        q_item.is_lf    = (s_tdata == CHAR_LF);
        q_item.is_semi  = (s_tdata == CHAR_SEMI);
        // letters a-f / A-F: low nibble 1..6 maps to 10..15
        if (is_digit) begin
            q_item.hex_val = s_tdata[3:0];
        end else begin
            q_item.hex_val = s_tdata[3:0] + 4'd9;
        end
    end

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

endmodule

// ----- rtl/chd_queue.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// chd_queue
// Short first-in first-out queue of classified requests.
// ---------------------------------------------------------------------------
module chd_queue #(
    parameter int DEPTH = chd_pkg::QUEUE_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  chd_pkg::chd_item_t push_item,
    output logic               full,
    output logic               pop_valid,
    input  logic               pop_ready,
    output chd_pkg::chd_item_t pop_item
);
    import chd_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    chd_item_t       mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            pop;

    assign full      = (count_reg == CW'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop       = pop_valid && pop_ready;
    assign pop_item  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        count_next = count_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- rtl/chd_back.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// chd_back
// Chunk grammar parser with size counter and registered result slot.
// ---------------------------------------------------------------------------
module chd_back #(
    parameter int SIZE_BITS = chd_pkg::SIZE_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  chd_pkg::chd_item_t in_item,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [7:0]         m_tdata,
    output logic [1:0]         m_tuser
);
    import chd_pkg::*;

    typedef enum logic [3:0] {
        PH_LEAD    = 4'd0,
        PH_DIGITS  = 4'd1,
        PH_TRAIL   = 4'd2,
        PH_EXT     = 4'd3,
        PH_EXT_CR  = 4'd4,
        PH_SIZE_LF = 4'd5,
        PH_DATA    = 4'd6,
        PH_DATA_CR = 4'd7,
        PH_DATA_LF = 4'd8,
        PH_DONE    = 4'd9,
        PH_ERROR   = 4'd10
    } phase_t;

    phase_t               phase_reg, phase_next;
    logic [SIZE_BITS-1:0] left_reg, left_next;
    logic                 out_valid_reg, out_valid_next;
    logic [7:0]           out_byte_reg, out_byte_next;
    chd_status_t          out_status_reg, out_status_next;

    logic                 take;
    logic                 emit;
    logic [7:0]           emit_byte;
    chd_status_t          emit_status;
    logic                 overflow;
    logic                 size_zero;
    logic [SIZE_BITS-1:0] shifted;

    assign in_ready  = !out_valid_reg || m_tready;
    assign take      = in_valid && in_ready;
    assign overflow  = (left_reg[SIZE_BITS-1 -: 4] != 4'd0);
    assign size_zero = (left_reg == '0);
    assign shifted   = {left_reg[SIZE_BITS-5:0], in_item.hex_val};

    always_comb begin
        phase_next  = phase_reg;
        left_next   = left_reg;
        emit        = 1'b0;
        emit_byte   = 8'd0;
        emit_status = ST_MALFORMED;

        if (take) begin
            if (in_item.cmd == CMD_END) begin
                emit = 1'b1;
                if (phase_reg == PH_ERROR) begin
                    emit_status = ST_MALFORMED;
                end else if (phase_reg == PH_DONE) begin
                    emit_status = ST_COMPLETE;
                end else begin
                    emit_status = ST_TRUNCATED;
                end
                phase_next = PH_LEAD;
                left_next  = '0;
            end else begin
                case (phase_reg)
                    PH_LEAD: begin
                        if (!in_item.is_blank) begin
                            if (in_item.is_hex && !overflow) begin
                                left_next  = shifted;
                                phase_next = PH_DIGITS;
                            end else begin
                                emit       = 1'b1;
                                phase_next = PH_ERROR;
                            end
                        end
                    end
                    PH_DIGITS: begin
                        if (in_item.is_hex) begin
                            if (overflow) begin
                                emit       = 1'b1;
                                phase_next = PH_ERROR;
                            end else begin
                                left_next = shifted;
                            end
                        end else if (in_item.is_blank) begin
                            phase_next = PH_TRAIL;
                        end else if (in_item.is_semi) begin
                            phase_next = PH_EXT;
                        end else if (in_item.is_cr) begin
                            phase_next = PH_SIZE_LF;
                        end else begin
                            emit       = 1'b1;
                            phase_next = PH_ERROR;
                        end
                    end
                    PH_TRAIL: begin
                        if (in_item.is_semi) begin
                            phase_next = PH_EXT;
                        end else if (in_item.is_cr) begin
                            phase_next = PH_SIZE_LF;
                        end else if (!in_item.is_blank) begin
                            emit       = 1'b1;
                            phase_next = PH_ERROR;
                        end
                    end
                    PH_EXT: begin
                        if (in_item.is_cr) begin
                            phase_next = PH_EXT_CR;
                        end
                    end
                    PH_EXT_CR: begin
                        // a cr without lf inside an extension is extension text
                        if (in_item.is_lf) begin
                            phase_next = size_zero ? PH_DONE : PH_DATA;
                        end else if (!in_item.is_cr) begin
                            phase_next = PH_EXT;
                        end
                    end
                    PH_SIZE_LF: begin
                        if (in_item.is_lf) begin
                            phase_next = size_zero ? PH_DONE : PH_DATA;
                        end else begin
                            emit       = 1'b1;
                            phase_next = PH_ERROR;
                        end
                    end
                    PH_DATA: begin
                        emit        = 1'b1;
                        emit_byte   = in_item.data;
                        emit_status = ST_DATA;
                        left_next   = left_reg - SIZE_BITS'(1);
                        if (left_reg == SIZE_BITS'(1)) begin
                            phase_next = PH_DATA_CR;
                        end
                    end
                    PH_DATA_CR: begin
                        if (in_item.is_cr) begin
                            phase_next = PH_DATA_LF;
                        end else begin
                            emit       = 1'b1;
                            phase_next = PH_ERROR;
                        end
                    end
                    PH_DATA_LF: begin
                        if (in_item.is_lf) begin
                            phase_next = PH_LEAD;
                            left_next  = '0;
                        end else begin
                            emit       = 1'b1;
                            phase_next = PH_ERROR;
                        end
                    end
                    PH_DONE: begin
                        phase_next = PH_DONE;
                    end
                    PH_ERROR: begin
                        phase_next = PH_ERROR;
                    end
                    default: begin
                        emit       = 1'b1;
                        phase_next = PH_ERROR;
                    end
                endcase
            end
        end

        out_valid_next  = out_valid_reg;
        out_byte_next   = out_byte_reg;
        out_status_next = out_status_reg;
        if (take && emit) begin
            out_valid_next  = 1'b1;
            out_byte_next   = emit_byte;
            out_status_next = emit_status;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_LEAD;
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            left_reg      <= left_next;
            out_valid_reg <= out_valid_next;
        end
        out_byte_reg   <= out_byte_next;
        out_status_reg <= out_status_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = out_status_reg;

endmodule

// ----- rtl/http_chunked_body_decoder_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// http_chunked_body_decoder_top
// Decodes an HTTP/1.1 chunked body stream into payload bytes and status.
// ---------------------------------------------------------------------------
// Takes one body byte (tuser = 0) or end-of-body marker (tuser = 1) per
// cycle and sustains one request per clock while m_tready stays high.
// Each request is classified combinationally as it is accepted, waits in a
// four-entry queue and goes to the parser, whose single state update and
// size counter step per byte set the rate; it passes the queue and then the
// output register before m_tvalid rises. Payload bytes come out with status
// 0, a malformed stream gives one status 2 result and then stays silent
// until the end-of-body marker, which always reports complete, malformed or
// truncated and rearms the parser. The queue and output register absorb
// stalls, but a long output stall fills the queue and drops s_tready.
module http_chunked_body_decoder_top #(
    parameter int SIZE_BITS = chd_pkg::SIZE_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] body_byte
    input  logic        s_tuser,   // [0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic [1:0]  m_tuser    // [1:0] status
);
    import chd_pkg::*;

    chd_item_t push_item;
    chd_item_t pop_item;
    logic      q_full;
    logic      q_push;
    logic      pop_valid;
    logic      pop_ready;

    chd_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    chd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item)
    );

    chd_back #(
        .SIZE_BITS (SIZE_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (pop_valid),
        .in_ready (pop_ready),
        .in_item  (pop_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ----- rtl/chd_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// chd_port_checks
// Port-level checks for the chunked body decoder, bound to the top level.
// ---------------------------------------------------------------------------
module chd_port_checks (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic       s_tuser,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [1:0] m_tuser
);
    import chd_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // only data results carry a byte
    a_status_zero_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != ST_DATA) |-> m_tdata == 8'd0)
        else $error("non-data result with nonzero byte");

    // reset empties the output slot
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // queue is empty right after reset, so a request can be taken
    a_ready_after_reset: assert property (@(posedge aclk)
        $rose(aresetn) |-> s_tready)
        else $error("input not ready after reset");

    // no result is offered right after reset
    a_no_early_result: assert property (@(posedge aclk)
        $rose(aresetn) |-> !m_tvalid)
        else $error("result before any request");

endmodule

bind http_chunked_body_decoder_top chd_port_checks u_chd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
